[rtl/gsp_pkg.sv]
// Shared widths, register indexes and reset values of the glyph shelf packer.
package gsp_pkg;

  localparam int unsigned GlyphW   = 12;
  localparam int unsigned PageDimW = 13;
  localparam int unsigned PosXW    = 13;
  localparam int unsigned PosYW    = 14;
  localparam int unsigned PageW    = 8;
  localparam int unsigned PageTotW = 9;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] REG_PAGE_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_PAGE_HEIGHT = 1'b1;

  localparam logic [PageDimW-1:0] PAGE_WIDTH_RST  = 13'd512;
  localparam logic [PageDimW-1:0] PAGE_HEIGHT_RST = 13'd512;

  localparam logic [PosYW-1:0] Y_MAX    = 14'd16383;
  localparam logic [PageW-1:0] PAGE_MAX = 8'd255;

  typedef logic [GlyphW-1:0]   glyph_dim_t;
  typedef logic [PageDimW-1:0] page_dim_t;
  typedef logic [PosXW-1:0]    pos_x_t;
  typedef logic [PosYW-1:0]    pos_y_t;
  typedef logic [PageW-1:0]    page_t;
  typedef logic [PageTotW-1:0] page_tot_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;

endpackage

[rtl/gsp_if.sv]
// Stream interfaces of the glyph shelf packer: glyph input, placement output, register writes.
interface gsp_in_if;
  import gsp_pkg::*;
  logic       valid;
  logic       ready;
  glyph_dim_t glyph_width;
  glyph_dim_t glyph_height;
  logic       final_glyph;
  modport source (output valid, glyph_width, glyph_height, final_glyph, input ready);
  modport sink   (input valid, glyph_width, glyph_height, final_glyph, output ready);
endinterface

interface gsp_out_if;
  import gsp_pkg::*;
  logic       valid;
  logic       ready;
  page_t      page_index;
  pos_x_t     pos_x;
  pos_y_t     pos_y;
  glyph_dim_t tallest_so_far;
  page_tot_t  page_total;
  logic       end_of_shelf;
  logic       end_of_set;
  logic       forced_break;
  modport source (output valid, page_index, pos_x, pos_y, tallest_so_far, page_total,
                  end_of_shelf, end_of_set, forced_break, input ready);
  modport sink   (input valid, page_index, pos_x, pos_y, tallest_so_far, page_total,
                  end_of_shelf, end_of_set, forced_break, output ready);
endinterface

interface gsp_cfg_if;
  import gsp_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  page_dim_t data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/glyph_shelf_packer.sv]
// Glyph shelf packer: places glyph boxes on shelves of atlas pages, emits each shelf on close.
//
//   channel  dir  payload                                           item
//   cfg_i    in   index, data                                       one register write
//   in_i     in   glyph_width, glyph_height, final_glyph            one glyph box
//   out_o    out  page_index, pos_x, pos_y, tallest_so_far,         one placed glyph
//                 page_total, end_of_shelf, end_of_set, forced_break
//
// A glyph that stays on the open shelf is stored directly. Closing a shelf of n glyphs
// runs a setup state, then n results, one x-store read per result, and then stores
// the glyph that caused the close. A final glyph adds its own close.
// Output backpressure holds the emission loop. Reset sets both page registers to 512;
// the x store needs no clearing.
module glyph_shelf_packer #(
  parameter int unsigned SHELF_SLOTS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  gsp_cfg_if.sink      cfg_i,
  gsp_in_if.sink       in_i,
  gsp_out_if.source    out_o
);
  import gsp_pkg::*;

  localparam int unsigned FillW = $clog2(SHELF_SLOTS + 1);
  localparam int unsigned IdxW  = (SHELF_SLOTS > 1) ? $clog2(SHELF_SLOTS) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLOSE = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_STORE = 2'd3;

  logic [1:0]       state_q, state_d;
  page_dim_t        pw_q, ph_q;
  pos_x_t           pen_x_q, pen_x_d;
  pos_y_t           shelf_y_q, shelf_y_d;
  glyph_dim_t       smh_q, smh_d;
  glyph_dim_t       tall_q, tall_d;
  page_t            page_q, page_d;
  logic [FillW-1:0] fill_q, fill_d;
  glyph_dim_t       g_w_q, g_w_d, g_h_q, g_h_d;
  logic             g_last_q, g_last_d;
  logic             cl_last_q, cl_last_d;
  logic             forced_q, forced_d;
  pos_y_t           top_q, top_d;
  logic [FillW-1:0] cnt_q, cnt_d;
  logic [FillW-1:0] idx_q, idx_d;

  logic             out_valid_q, out_valid_d;
  page_t            o_page_q;
  pos_x_t           o_x_q;
  pos_y_t           o_y_q;
  glyph_dim_t       o_tall_q;
  page_tot_t        o_ptot_q;
  logic             o_eos_q, o_eoset_q, o_forced_q;

  pos_x_t           mem_q [SHELF_SLOTS];
  pos_x_t           rdata_q;
  logic             mem_we, mem_re;
  logic [IdxW-1:0]  mem_waddr, mem_raddr;
  pos_x_t           mem_wdata;

  logic             in_fire, over, full, ld, last_one;
  logic [PosYW:0]   x_sum;
  logic             st_en, st_last;
  pos_x_t           st_base;
  glyph_dim_t       st_w, st_h;
  logic [PosYW:0]   st_sum;
  logic [PosYW:0]   need, new_y;
  logic             move;
  pos_y_t           top_c;
  logic [FillW-1:0] idx_nxt;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid & in_i.ready;

  assign x_sum = {2'b00, pen_x_q} + {3'b000, in_i.glyph_width};
  assign over  = x_sum > {2'b00, pw_q};
  assign full  = (fill_q == FillW'(SHELF_SLOTS));

  assign ld       = ~out_valid_q | out_o.ready;
  assign last_one = (idx_q == cnt_q - FillW'(1));
  assign idx_nxt  = idx_q + FillW'(1);

  assign need  = {1'b0, shelf_y_q} + (cl_last_q ? {3'b000, smh_q} : {2'b00, smh_q, 1'b0});
  assign move  = need >= {2'b00, ph_q};
  assign top_c = move ? '0 : shelf_y_q;
  assign new_y = {1'b0, top_c} + {3'b000, smh_q};

  always_comb begin
    st_en   = 1'b0;
    st_base = '0;
    st_w    = g_w_q;
    st_h    = g_h_q;
    st_last = g_last_q;
    if (state_q == S_IDLE && in_fire && !(over || full)) begin
      st_en   = 1'b1;
      st_base = pen_x_q;
      st_w    = in_i.glyph_width;
      st_h    = in_i.glyph_height;
      st_last = in_i.final_glyph;
    end else if (state_q == S_IDLE && in_fire && fill_q == '0) begin
      st_en   = 1'b1;
      st_w    = in_i.glyph_width;
      st_h    = in_i.glyph_height;
      st_last = in_i.final_glyph;
    end else if (state_q == S_STORE) begin
      st_en   = 1'b1;
    end
  end

  assign st_sum    = {2'b00, st_base} + {3'b000, st_w};
  assign mem_we    = st_en;
  assign mem_waddr = fill_q[IdxW-1:0];
  assign mem_wdata = st_base;
  assign mem_re    = (state_q == S_CLOSE) || (state_q == S_EMIT && ld && !last_one);
  assign mem_raddr = (state_q == S_CLOSE) ? '0 : idx_nxt[IdxW-1:0];

  always_comb begin
    state_d     = state_q;
    pen_x_d     = pen_x_q;
    shelf_y_d   = shelf_y_q;
    smh_d       = smh_q;
    tall_d      = tall_q;
    page_d      = page_q;
    fill_d      = fill_q;
    g_w_d       = g_w_q;
    g_h_d       = g_h_q;
    g_last_d    = g_last_q;
    cl_last_d   = cl_last_q;
    forced_d    = forced_q;
    top_d       = top_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q & ~out_o.ready;

    if (st_en) begin
      fill_d  = fill_q + FillW'(1);
      pen_x_d = st_sum[PosXW-1:0];
      if (smh_q < st_h) smh_d = st_h;
      if (tall_q < st_h) tall_d = st_h;
      if (st_last) begin
        cl_last_d = 1'b1;
        forced_d  = 1'b0;
        state_d   = S_CLOSE;
      end else begin
        state_d   = S_IDLE;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire && !st_en) begin
          g_w_d     = in_i.glyph_width;
          g_h_d     = in_i.glyph_height;
          g_last_d  = in_i.final_glyph;
          cl_last_d = 1'b0;
          forced_d  = ~over;
          state_d   = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (move && page_q != PAGE_MAX) page_d = page_q + PageW'(1);
        shelf_y_d = (new_y > {1'b0, Y_MAX}) ? Y_MAX : new_y[PosYW-1:0];
        top_d     = top_c;
        cnt_d     = fill_q;
        idx_d     = '0;
        pen_x_d   = '0;
        smh_d     = '0;
        fill_d    = '0;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (ld) begin
          out_valid_d = 1'b1;
          if (last_one) begin
            if (cl_last_q) begin
              shelf_y_d = '0;
              tall_d    = '0;
              page_d    = '0;
              state_d   = S_IDLE;
            end else begin
              state_d   = S_STORE;
            end
          end else begin
            idx_d = idx_nxt;
          end
        end
      end
      S_STORE: ;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pw_q        <= PAGE_WIDTH_RST;
      ph_q        <= PAGE_HEIGHT_RST;
      pen_x_q     <= '0;
      shelf_y_q   <= '0;
      smh_q       <= '0;
      tall_q      <= '0;
      page_q      <= '0;
      fill_q      <= '0;
      cl_last_q   <= 1'b0;
      forced_q    <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pen_x_q     <= pen_x_d;
      shelf_y_q   <= shelf_y_d;
      smh_q       <= smh_d;
      tall_q      <= tall_d;
      page_q      <= page_d;
      fill_q      <= fill_d;
      cl_last_q   <= cl_last_d;
      forced_q    <= forced_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          REG_PAGE_WIDTH:  pw_q <= cfg_i.data;
          REG_PAGE_HEIGHT: ph_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    g_w_q    <= g_w_d;
    g_h_q    <= g_h_d;
    g_last_q <= g_last_d;
    top_q    <= top_d;
    if (state_q == S_EMIT && ld) begin
      o_page_q   <= page_q;
      o_x_q      <= rdata_q;
      o_y_q      <= top_q;
      o_tall_q   <= tall_q;
      o_ptot_q   <= (cl_last_q && last_one) ? {1'b0, page_q} + PageTotW'(1) : '0;
      o_eos_q    <= last_one;
      o_eoset_q  <= cl_last_q & last_one;
      o_forced_q <= forced_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.page_index     = o_page_q;
  assign out_o.pos_x          = o_x_q;
  assign out_o.pos_y          = o_y_q;
  assign out_o.tallest_so_far = o_tall_q;
  assign out_o.page_total     = o_ptot_q;
  assign out_o.end_of_shelf   = o_eos_q;
  assign out_o.end_of_set     = o_eoset_q;
  assign out_o.forced_break   = o_forced_q;

endmodule

[rtl/gsp_check.sv]
// Port checker of the glyph shelf packer and its bind.
module gsp_check (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid,
  input logic                out_ready,
  input gsp_pkg::page_t      page_index,
  input gsp_pkg::pos_x_t     pos_x,
  input gsp_pkg::page_tot_t  page_total,
  input logic                end_of_shelf,
  input logic                end_of_set
);
  import gsp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(page_index))
    else $error("stalled placement item changed");

  a_set_ends_shelf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && end_of_set |-> end_of_shelf)
    else $error("set ended inside an open shelf");

  a_total_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !end_of_set |-> page_total == '0)
    else $error("page count shown before end of set");

  a_total_matches_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && end_of_set |-> page_total == {1'b0, page_index} + PageTotW'(1))
    else $error("page count disagrees with last page");

endmodule

bind glyph_shelf_packer gsp_check u_gsp_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .page_index   (out_o.page_index),
  .pos_x        (out_o.pos_x),
  .page_total   (out_o.page_total),
  .end_of_shelf (out_o.end_of_shelf),
  .end_of_set   (out_o.end_of_set)
);

[sim/glyph_shelf_packer_test.sv]
// Self-checking bench for the glyph shelf packer: predicts and compares every placed glyph item.
module glyph_shelf_packer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gsp_pkg::*;

  localparam int unsigned SHELF_SLOTS = 32;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned HOLD_OFF    = 400;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    page_t      page_index;
    pos_x_t     pos_x;
    pos_y_t     pos_y;
    glyph_dim_t tallest_so_far;
    page_tot_t  page_total;
    logic       end_of_shelf;
    logic       end_of_set;
    logic       forced_break;
  } placement_t;

  class atlas_layout;
    page_dim_t   page_width;
    page_dim_t   page_height;
    int unsigned pen_x;
    int unsigned shelf_y;
    int unsigned shelf_h;
    int unsigned tallest;
    int unsigned cur_page;
    int unsigned fill;
    pos_x_t      x_slots[SHELF_SLOTS];
    placement_t  due_places[$];
    int unsigned mismatches;

    function new();
      page_width  = PAGE_WIDTH_RST;
      page_height = PAGE_HEIGHT_RST;
      mismatches  = 0;
      clear_layout();
    endfunction

    function void clear_layout();
      pen_x    = 0;
      shelf_y  = 0;
      shelf_h  = 0;
      tallest  = 0;
      cur_page = 0;
      fill     = 0;
    endfunction

    function void close_shelf(bit last, bit forced);
      int unsigned need;
      int unsigned top;
      int unsigned i;
      placement_t  p;
      if (fill == 0) begin
        pen_x   = 0;
        shelf_h = 0;
        return;
      end
      need = last ? shelf_y + shelf_h : shelf_y + 2 * shelf_h;
      if (need >= page_height) begin
        if (cur_page < PAGE_MAX) cur_page++;
        top = 0;
      end else begin
        top = shelf_y;
      end
      for (i = 0; i < fill; i++) begin
        p.page_index     = page_t'(cur_page);
        p.pos_x          = x_slots[i];
        p.pos_y          = pos_y_t'(top);
        p.tallest_so_far = glyph_dim_t'(tallest);
        p.page_total     = '0;
        p.end_of_shelf   = (i + 1 == fill);
        p.end_of_set     = 1'b0;
        p.forced_break   = forced;
        due_places = {due_places, p};
      end
      top += shelf_h;
      shelf_y = (top > Y_MAX) ? Y_MAX : top;
      pen_x   = 0;
      shelf_h = 0;
      fill    = 0;
    endfunction

    function void note_glyph(glyph_dim_t w, glyph_dim_t h, bit last);
      placement_t p;
      if (pen_x + w > page_width) begin
        close_shelf(1'b0, 1'b0);
      end else if (fill >= SHELF_SLOTS) begin
        close_shelf(1'b0, 1'b1);
      end
      if (fill < SHELF_SLOTS) x_slots[fill] = pos_x_t'(pen_x);
      fill++;
      pen_x = (pen_x + w) & 32'h1FFF;
      if (shelf_h < h) shelf_h = h;
      if (tallest < h) tallest = h;
      if (last) begin
        close_shelf(1'b1, 1'b0);
        p = due_places[due_places.size() - 1];
        p.page_total = page_tot_t'(cur_page + 1);
        p.end_of_set = 1'b1;
        due_places[due_places.size() - 1] = p;
        clear_layout();
      end
    endfunction

    function string show(placement_t p);
      return $sformatf("page %0d x %0d y %0d tallest %0d total %0d eos %0b eset %0b fb %0b",
                       p.page_index, p.pos_x, p.pos_y, p.tallest_so_far, p.page_total,
                       p.end_of_shelf, p.end_of_set, p.forced_break);
    endfunction

    function void check_placement(placement_t got);
      placement_t want;
      if (due_places.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: %s", show(got));
        return;
      end
      want = due_places.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("wrong item: expected %s", show(want));
          $display("            actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          steady;
  bit          stall_req;
  int unsigned cycles = 0;
  atlas_layout board;

  gsp_cfg_if cfg_bus ();
  gsp_in_if  glyph_bus ();
  gsp_out_if place_bus ();

  glyph_shelf_packer #(
    .SHELF_SLOTS(SHELF_SLOTS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (glyph_bus),
    .out_o (place_bus)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    placement_t got;
    if (place_bus.valid === 1'b1 && place_bus.ready === 1'b1) begin
      got.page_index     = place_bus.page_index;
      got.pos_x          = place_bus.pos_x;
      got.pos_y          = place_bus.pos_y;
      got.tallest_so_far = place_bus.tallest_so_far;
      got.page_total     = place_bus.page_total;
      got.end_of_shelf   = place_bus.end_of_shelf;
      got.end_of_set     = place_bus.end_of_set;
      got.forced_break   = place_bus.forced_break;
      board.check_placement(got);
    end
  end

  initial begin
    place_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        place_bus.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
      end
      place_bus.ready <= steady || ($urandom_range(99) >= 26);
    end
  end

  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < 26);
  endfunction

  function automatic glyph_dim_t pick_width(int unsigned span);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 14) return '1;
    if (roll < 22) return glyph_dim_t'($urandom_range(4095));
    return glyph_dim_t'($urandom_range(span));
  endfunction

  function automatic glyph_dim_t pick_height(int unsigned span);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 9) return '1;
    if (roll < 17) return glyph_dim_t'($urandom_range(4095));
    return glyph_dim_t'($urandom_range(span));
  endfunction

  task automatic send_glyph(glyph_dim_t w, glyph_dim_t h, bit last);
    while (take_gap()) begin
      glyph_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    glyph_bus.valid        <= 1'b1;
    glyph_bus.glyph_width  <= w;
    glyph_bus.glyph_height <= h;
    glyph_bus.final_glyph  <= last;
    do @(posedge clk_i); while (glyph_bus.ready !== 1'b1);
    board.note_glyph(w, h, last);
  endtask

  task automatic quiesce();
    glyph_bus.valid <= 1'b0;
    while (board.due_places.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_page(page_dim_t w, page_dim_t h);
    quiesce();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= REG_PAGE_WIDTH;
    cfg_bus.data  <= w;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    cfg_bus.index <= REG_PAGE_HEIGHT;
    cfg_bus.data  <= h;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    board.page_width  = w;
    board.page_height = h;
  endtask

  task automatic run_sets(int unsigned count, int unsigned w_span, int unsigned h_span,
                          int unsigned longest);
    int unsigned left;
    int unsigned len;
    int unsigned i;
    left = count;
    while (left > 0) begin
      len = $urandom_range(longest, 1);
      if (len > left) len = left;
      for (i = 0; i < len; i++) send_glyph(pick_width(w_span), pick_height(h_span), i + 1 == len);
      left -= len;
    end
  endtask

  initial begin
    int unsigned i;
    board = new();
    rst_ni                 <= 1'b0;
    steady                  = 1'b0;
    stall_req               = 1'b0;
    cfg_bus.valid          <= 1'b0;
    cfg_bus.index          <= REG_PAGE_WIDTH;
    cfg_bus.data           <= '0;
    glyph_bus.valid        <= 1'b0;
    glyph_bus.glyph_width  <= '0;
    glyph_bus.glyph_height <= '0;
    glyph_bus.final_glyph  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset page size: zero glyph, oversized glyph, tall first shelf, exact fill
    send_glyph(12'd0, 12'd0, 1'b1);
    send_glyph(12'd4095, 12'd4095, 1'b0);
    send_glyph(12'd1, 12'd1, 1'b1);
    send_glyph(12'd100, 12'd10, 1'b0);
    send_glyph(12'd200, 12'd20, 1'b0);
    send_glyph(12'd212, 12'd5, 1'b0);
    send_glyph(12'd1, 12'd30, 1'b0);
    send_glyph(12'd0, 12'd7, 1'b1);

    set_page('0, '0);
    send_glyph(12'd5, 12'd2, 1'b0);
    send_glyph(12'd0, 12'd0, 1'b0);
    send_glyph(12'd3, 12'd9, 1'b0);
    send_glyph(12'd4095, 12'd4095, 1'b1);

    set_page('1, '1);
    send_glyph(12'd4095, 12'd4095, 1'b0);
    send_glyph(12'd4095, 12'd1, 1'b0);
    send_glyph(12'd1, 12'd4095, 1'b1);

    set_page(page_dim_t'($urandom_range(1500, 200)), page_dim_t'($urandom_range(3000, 100)));
    steady = 1'b1;
    run_sets(30, 200, 300, 30);
    steady = 1'b0;
    run_sets(30, 200, 300, 30);

    // hold the output while long shelves keep arriving
    set_page(13'd4096, 13'd4096);
    stall_req = 1'b1;
    run_sets(60, 12, 400, 80);

    set_page(13'd1, 13'd8191);
    run_sets(20, 1, 4095, 20);

    set_page(13'd2048, 13'd1);
    run_sets(20, 600, 50, 20);

    // one shelf per glyph, enough to saturate the page counter
    set_page(13'd1, 13'd0);
    for (i = 0; i < 262; i++)
      send_glyph(glyph_dim_t'($urandom_range(4095, 2)), pick_height(4095), i == 261);

    quiesce();
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
